// ===== sv/mqe_pkg.sv =====
package mqe_pkg;

    // default context count
    localparam int NUM_CONTEXTS_DEF = 19;

    // probability state range
    localparam logic [5:0] LAST_STATE = 6'd46;

    // interval and code register constants
    localparam logic [15:0] A_INIT    = 16'h8000;
    localparam logic [15:0] QE_SWITCH = 16'h5601;
    localparam logic [3:0]  CT_INIT   = 4'd12;
    localparam logic [3:0]  CT_STUFF  = 4'd7;
    localparam logic [3:0]  CT_PLAIN  = 4'd8;
    localparam logic [27:0] C_NO_MSB  = 28'h7FFFFFF;
    localparam logic [27:0] C_LOW16   = 28'h000FFFF;
    localparam logic [27:0] C_HALF    = 28'h0008000;
    localparam logic [7:0]  BYTE_FF   = 8'hFF;

    typedef enum logic [1:0] {
        CMD_ENCODE = 2'd0,
        CMD_FLUSH  = 2'd1,
        CMD_LOAD   = 2'd2,
        CMD_START  = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t       cmd;
        logic [4:0] context_req;
        logic       decision;
        logic [5:0] init_state;
        logic       init_mps;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last;
    } result_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic ctx_load;
        logic start_cw;
        logic code;
        logic renorm;
        logic flush_set;
        logic flush_out;
        logic flush_last;
        logic finish;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_in_range;
        logic code_renorm;
        logic renorm_done;
        logic slot_ok;
    } dp_status_t;

    function automatic logic [15:0] qe_value(input logic [5:0] st);
        logic [15:0] q;
        begin
            case (st)
                6'd0:  q = 16'h5601;  6'd1:  q = 16'h3401;  6'd2:  q = 16'h1801;
                6'd3:  q = 16'h0AC1;  6'd4:  q = 16'h0521;  6'd5:  q = 16'h0221;
                6'd6:  q = 16'h5601;  6'd7:  q = 16'h5401;  6'd8:  q = 16'h4801;
                6'd9:  q = 16'h3801;  6'd10: q = 16'h3001;  6'd11: q = 16'h2401;
                6'd12: q = 16'h1C01;  6'd13: q = 16'h1601;  6'd14: q = 16'h5601;
                6'd15: q = 16'h5401;  6'd16: q = 16'h5101;  6'd17: q = 16'h4801;
                6'd18: q = 16'h3801;  6'd19: q = 16'h3401;  6'd20: q = 16'h3001;
                6'd21: q = 16'h2801;  6'd22: q = 16'h2401;  6'd23: q = 16'h2201;
                6'd24: q = 16'h1C01;  6'd25: q = 16'h1801;  6'd26: q = 16'h1601;
                6'd27: q = 16'h1401;  6'd28: q = 16'h1201;  6'd29: q = 16'h1101;
                6'd30: q = 16'h0AC1;  6'd31: q = 16'h09C1;  6'd32: q = 16'h08A1;
                6'd33: q = 16'h0521;  6'd34: q = 16'h0441;  6'd35: q = 16'h02A1;
                6'd36: q = 16'h0221;  6'd37: q = 16'h0141;  6'd38: q = 16'h0111;
                6'd39: q = 16'h0085;  6'd40: q = 16'h0049;  6'd41: q = 16'h0025;
                6'd42: q = 16'h0015;  6'd43: q = 16'h0009;  6'd44: q = 16'h0005;
                6'd45: q = 16'h0001;
                default: q = 16'h5601;
            endcase
            return q;
        end
    endfunction

    function automatic logic [5:0] next_mps(input logic [5:0] st);
        logic [5:0] n;
        begin
            case (st)
                6'd5:  n = 6'd38;
                6'd13: n = 6'd29;
                6'd45: n = 6'd45;
                6'd46: n = 6'd46;
                default: n = st + 6'd1;
            endcase
            return n;
        end
    endfunction

    function automatic logic [5:0] next_lps(input logic [5:0] st);
        logic [5:0] n;
        begin
            case (st)
                6'd0:  n = 6'd1;   6'd1:  n = 6'd6;   6'd2:  n = 6'd9;
                6'd3:  n = 6'd12;  6'd4:  n = 6'd29;  6'd5:  n = 6'd33;
                6'd6:  n = 6'd6;   6'd7:  n = 6'd14;  6'd8:  n = 6'd14;
                6'd9:  n = 6'd14;  6'd10: n = 6'd17;  6'd11: n = 6'd18;
                6'd12: n = 6'd20;  6'd13: n = 6'd21;  6'd14: n = 6'd14;
                6'd15: n = 6'd14;  6'd16: n = 6'd15;  6'd17: n = 6'd16;
                6'd18: n = 6'd17;  6'd19: n = 6'd18;  6'd20: n = 6'd19;
                6'd21: n = 6'd19;
                6'd46: n = 6'd46;
                // states 22 to 45 step back by two
                default: n = st - 6'd2;
            endcase
            return n;
        end
    endfunction

    // state index of a context before it is first loaded
    function automatic logic [5:0] ctx_reset_index(input logic [5:0] idx);
        logic [5:0] r;
        begin
            case (idx)
                6'd0:    r = 6'd46;
                6'd1:    r = 6'd3;
                6'd2:    r = 6'd4;
                default: r = 6'd0;
            endcase
            return r;
        end
    endfunction

endpackage

// ===== sv/mqe_ram.sv =====
module mqe_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/mqe_ctrl.sv =====
module mqe_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  mqe_pkg::cmd_t          item_cmd,
    output logic                   item_stall,
    input  mqe_pkg::dp_status_t    status,
    output mqe_pkg::ctrl_cmd_t     cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CODE,
        S_RENORM,
        S_FL_SET,
        S_FL_OUT1,
        S_FL_OUT2,
        S_FL_LAST,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   stall_reg;
    logic   accept;

    assign accept     = item_valid && !stall_reg;
    assign item_stall = stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.capture = 1'b1;
                    unique case (item_cmd)
                        mqe_pkg::CMD_ENCODE:
                        begin
                            if (status.item_in_range)
                            begin
                                state_next = S_CODE;
                            end
                        end
                        mqe_pkg::CMD_FLUSH:
                        begin
                            state_next = S_FL_SET;
                        end
                        mqe_pkg::CMD_LOAD:
                        begin
                            cmd.ctx_load = status.item_in_range;
                        end
                        mqe_pkg::CMD_START:
                        begin
                            cmd.start_cw = 1'b1;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CODE:
            begin
                cmd.code   = 1'b1;
                state_next = status.code_renorm ? S_RENORM : S_FINISH;
            end
            S_RENORM:
            begin
                if (status.slot_ok)
                begin
                    cmd.renorm = 1'b1;
                    if (status.renorm_done)
                    begin
                        state_next = S_FINISH;
                    end
                end
            end
            S_FL_SET:
            begin
                cmd.flush_set = 1'b1;
                state_next    = S_FL_OUT1;
            end
            S_FL_OUT1:
            begin
                if (status.slot_ok)
                begin
                    cmd.flush_out = 1'b1;
                    state_next    = S_FL_OUT2;
                end
            end
            S_FL_OUT2:
            begin
                if (status.slot_ok)
                begin
                    cmd.flush_out = 1'b1;
                    state_next    = S_FL_LAST;
                end
            end
            S_FL_LAST:
            begin
                if (status.slot_ok)
                begin
                    cmd.flush_last = 1'b1;
                    state_next     = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.slot_ok)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            stall_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != S_IDLE);
        end
    end

endmodule

// ===== sv/mqe_dp.sv =====
module mqe_dp #(
    parameter int NUM_CONTEXTS = mqe_pkg::NUM_CONTEXTS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mqe_pkg::item_t         item,
    input  mqe_pkg::ctrl_cmd_t     cmd,
    output mqe_pkg::dp_status_t    status,
    input  logic                   result_stall,
    output logic                   result_valid,
    output mqe_pkg::result_t       result
);

    localparam int CTX_W   = (NUM_CONTEXTS > 1) ? $clog2(NUM_CONTEXTS) : 1;
    localparam int ENTRY_W = 7;
    localparam logic [6:0] CTX_LIMIT = 7'(NUM_CONTEXTS);

    // result of one byte output step
    typedef struct packed {
        logic [27:0] c;
        logic [3:0]  ct;
        logic [7:0]  pb;
        logic        emit;
        logic [7:0]  emit_byte;
    } bo_t;

    function automatic bo_t byte_out(input logic [27:0] x, input logic pv,
                                     input logic [7:0] pb);
        bo_t         r;
        logic [7:0]  b;
        logic [7:0]  b_inc;
        logic        stuffed;
        logic [27:0] xm;
        begin
            b           = pv ? pb : 8'h00;
            b_inc       = b + 8'd1;
            xm          = x;
            stuffed     = 1'b0;
            r.emit      = pv;
            r.emit_byte = pb;
            if (b == mqe_pkg::BYTE_FF)
            begin
                stuffed = 1'b1;
            end
            else if (x[27])
            begin
                // carry into the held byte
                r.emit_byte = b_inc;
                if (b_inc == mqe_pkg::BYTE_FF)
                begin
                    xm      = x & mqe_pkg::C_NO_MSB;
                    stuffed = 1'b1;
                end
            end
            if (stuffed)
            begin
                r.pb = xm[27:20];
                r.c  = {8'h00, xm[19:0]};
                r.ct = mqe_pkg::CT_STUFF;
            end
            else
            begin
                r.pb = xm[26:19];
                r.c  = {9'h000, xm[18:0]};
                r.ct = mqe_pkg::CT_PLAIN;
            end
            return r;
        end
    endfunction

    // coder registers
    logic [15:0] a_reg, a_next;
    logic [27:0] c_reg, c_next;
    logic [3:0]  ct_reg, ct_next;
    logic [7:0]  pb_reg, pb_next;
    logic        pv_reg, pv_next;

    // one byte held back to learn whether it is the item's last
    logic [7:0]  hold_reg, hold_next;
    logic        hold_valid_reg, hold_valid_next;

    mqe_pkg::result_t result_reg, result_next;
    logic             result_valid_reg, result_valid_next;

    logic             decision_reg;

    // context store
    logic [NUM_CONTEXTS-1:0] ctx_valid_reg;
    logic [CTX_W-1:0]        rd_addr_reg;
    logic                    rd_valid_reg;
    logic [5:0]              cx6;
    logic [CTX_W-1:0]        item_addr;
    logic                    ram_we;
    logic [CTX_W-1:0]        ram_waddr;
    logic [ENTRY_W-1:0]      ram_wdata;
    logic [ENTRY_W-1:0]      ram_q;
    logic [ENTRY_W-1:0]      ctx_word;

    // encode terms
    logic [5:0]  st_raw;
    logic [5:0]  st;
    logic [15:0] qe;
    logic [15:0] a_sub;
    logic [27:0] c_add;
    logic        mps;
    logic        mps_hit;
    logic        mps_new;
    logic [5:0]  st_new;

    // renorm and flush terms
    logic [15:0] a_sh;
    logic [27:0] c_sh;
    logic [3:0]  ct_dec;
    logic [28:0] flush_sum;
    logic [27:0] c_set;
    logic [27:0] c_fl;
    bo_t         bo_ren;
    bo_t         bo_fl;

    logic        emit_now;
    logic [7:0]  emit_byte;
    logic        slot_ok;

    assign cx6       = {1'b0, item.context_req};
    assign item_addr = cx6[CTX_W-1:0];

    mqe_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_CONTEXTS)
    ) u_ctx_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (item_addr),
        .rd_data (ram_q)
    );

    // an entry never written reads as its reset value
    assign ctx_word = rd_valid_reg ? ram_q
                    : {1'b0, mqe_pkg::ctx_reset_index(6'(rd_addr_reg))};

    assign st_raw  = ctx_word[5:0];
    assign st      = (st_raw > mqe_pkg::LAST_STATE) ? mqe_pkg::LAST_STATE : st_raw;
    assign mps     = ctx_word[6];
    assign qe      = mqe_pkg::qe_value(st);
    assign a_sub   = a_reg - qe;
    assign c_add   = c_reg + 28'(qe);
    assign mps_hit = (mps == decision_reg);
    assign mps_new = (!mps_hit && qe == mqe_pkg::QE_SWITCH && st != mqe_pkg::LAST_STATE)
                     ? ~mps : mps;
    assign st_new  = mps_hit ? mqe_pkg::next_mps(st) : mqe_pkg::next_lps(st);

    assign a_sh   = {a_reg[14:0], 1'b0};
    assign c_sh   = {c_reg[26:0], 1'b0};
    assign ct_dec = ct_reg - 4'd1;
    assign bo_ren = byte_out(c_sh, pv_reg, pb_reg);

    assign flush_sum = {1'b0, c_reg} + 29'(a_reg);
    assign c_fl      = c_reg << ct_reg;
    assign bo_fl     = byte_out(c_fl, pv_reg, pb_reg);

    always_comb
    begin
        c_set = c_reg | mqe_pkg::C_LOW16;
        if ({1'b0, c_set} >= flush_sum)
        begin
            c_set = c_set - mqe_pkg::C_HALF;
        end
    end

    // context writes
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = rd_addr_reg;
        ram_wdata = {mps_new, st_new};
        if (cmd.ctx_load)
        begin
            ram_we    = 1'b1;
            ram_waddr = item_addr;
            ram_wdata = {item.init_mps,
                         (item.init_state > mqe_pkg::LAST_STATE) ? mqe_pkg::LAST_STATE
                                                                  : item.init_state};
        end
        else if (cmd.code && (!mps_hit || !a_sub[15]))
        begin
            ram_we = 1'b1;
        end
    end

    assign slot_ok = !hold_valid_reg || !result_valid_reg || !result_stall;

    always_comb
    begin
        a_next    = a_reg;
        c_next    = c_reg;
        ct_next   = ct_reg;
        pb_next   = pb_reg;
        pv_next   = pv_reg;
        emit_now  = 1'b0;
        emit_byte = pb_reg;

        if (cmd.start_cw)
        begin
            a_next  = mqe_pkg::A_INIT;
            c_next  = '0;
            ct_next = mqe_pkg::CT_INIT;
            pb_next = '0;
            pv_next = 1'b0;
        end
        else if (cmd.code)
        begin
            if (mps_hit)
            begin
                if (a_sub[15])
                begin
                    a_next = a_sub;
                    c_next = c_add;
                end
                else if (a_sub < qe)
                begin
                    a_next = qe;
                end
                else
                begin
                    a_next = a_sub;
                    c_next = c_add;
                end
            end
            else
            begin
                if (a_sub < qe)
                begin
                    a_next = a_sub;
                    c_next = c_add;
                end
                else
                begin
                    a_next = qe;
                end
            end
        end
        else if (cmd.renorm)
        begin
            a_next  = a_sh;
            c_next  = c_sh;
            ct_next = ct_dec;
            if (ct_dec == 4'd0)
            begin
                c_next    = bo_ren.c;
                ct_next   = bo_ren.ct;
                pb_next   = bo_ren.pb;
                pv_next   = 1'b1;
                emit_now  = bo_ren.emit;
                emit_byte = bo_ren.emit_byte;
            end
        end
        else if (cmd.flush_set)
        begin
            c_next = c_set;
        end
        else if (cmd.flush_out)
        begin
            c_next    = bo_fl.c;
            ct_next   = bo_fl.ct;
            pb_next   = bo_fl.pb;
            pv_next   = 1'b1;
            emit_now  = bo_fl.emit;
            emit_byte = bo_fl.emit_byte;
        end
        else if (cmd.flush_last)
        begin
            emit_now  = pv_reg && (pb_reg != mqe_pkg::BYTE_FF);
            emit_byte = pb_reg;
            pv_next   = 1'b0;
        end
    end

    // hold byte and result register
    always_comb
    begin
        hold_next         = hold_reg;
        hold_valid_next   = hold_valid_reg;
        result_next       = result_reg;
        result_valid_next = result_valid_reg && result_stall;
        if (emit_now)
        begin
            if (hold_valid_reg)
            begin
                result_next.out_byte = hold_reg;
                result_next.last     = 1'b0;
                result_valid_next    = 1'b1;
            end
            hold_next       = emit_byte;
            hold_valid_next = 1'b1;
        end
        else if (cmd.finish && hold_valid_reg)
        begin
            result_next.out_byte = hold_reg;
            result_next.last     = 1'b1;
            result_valid_next    = 1'b1;
            hold_valid_next      = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg            <= mqe_pkg::A_INIT;
            c_reg            <= '0;
            ct_reg           <= mqe_pkg::CT_INIT;
            pb_reg           <= '0;
            pv_reg           <= 1'b0;
            hold_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            ctx_valid_reg    <= '0;
        end
        else
        begin
            a_reg            <= a_next;
            c_reg            <= c_next;
            ct_reg           <= ct_next;
            pb_reg           <= pb_next;
            pv_reg           <= pv_next;
            hold_valid_reg   <= hold_valid_next;
            result_valid_reg <= result_valid_next;
            if (ram_we)
            begin
                ctx_valid_reg[ram_waddr] <= 1'b1;
            end
        end
    end

    // payload registers, read address follows the ram read port
    always_ff @(posedge clk)
    begin
        hold_reg     <= hold_next;
        result_reg   <= result_next;
        rd_addr_reg  <= item_addr;
        rd_valid_reg <= ctx_valid_reg[item_addr];
        if (cmd.capture)
        begin
            decision_reg <= item.decision;
        end
    end

    assign status.item_in_range = ({2'b00, item.context_req} < CTX_LIMIT);
    assign status.code_renorm   = !mps_hit || !a_sub[15];
    assign status.renorm_done   = a_sh[15] || (a_sh == 16'h0000);
    assign status.slot_ok       = slot_ok;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== sv/mq_arithmetic_encoder.sv =====
// MQ binary arithmetic encoder: each input word is a command. Encode codes one
// decision in one context, load writes a context's state index (clamped to 46)
// and MPS bit, start resets A, C, the shift count and drops any pending byte,
// and flush terminates the codeword (SETBITS, two byte outputs, then the last
// byte unless it is 0xFF). Every input word yields zero to three result words
// of code bytes; last marks the final byte caused by that input word. Commands
// with a context label at or above NUM_CONTEXTS are ignored for encode and
// load. During an encode's renormalization (0 to 15 shifts) the interval and
// code registers are shifted one bit per cycle, and any byte output rides on
// the shift that empties the shift count. Each renormalization shift, flush
// byte output and closing step waits while a byte is already held back and the
// result register is full and stalled. Context state lives in a small RAM with
// one valid flop per entry, so it is usable right after reset with no clearing
// pass.
module mq_arithmetic_encoder #(
    parameter int NUM_CONTEXTS = mqe_pkg::NUM_CONTEXTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // command words
    input  logic              item_valid,
    output logic              item_stall,
    input  mqe_pkg::item_t    item,
    // code byte words
    output logic              result_valid,
    input  logic              result_stall,
    output mqe_pkg::result_t  result
);

    mqe_pkg::ctrl_cmd_t  cmd;
    mqe_pkg::dp_status_t status;

    // sequencing: decode, code step, renormalization, flush and last marking
    mqe_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_cmd   (item.cmd),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    // A, C, shift count, pending byte, context store and output register
    mqe_dp #(
        .NUM_CONTEXTS (NUM_CONTEXTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .status       (status),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule

// ===== sim/mq_arithmetic_encoder_tb.sv =====
module mq_arithmetic_encoder_tb;

    localparam int NCTX        = mqe_pkg::NUM_CONTEXTS_DEF;
    localparam int ITEMS       = 370;
    localparam int LIMIT       = 400000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 40;

    // one stimulus word plus, where it can be read off directly, the bytes it must give
    typedef struct packed {
        mqe_pkg::item_t w;
        logic           typed;
        logic [1:0]     n;
        logic [7:0]     b0;
        logic [7:0]     b1;
    } row_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             item_valid   = 1'b0;
    logic             item_stall;
    mqe_pkg::item_t   item         = '0;
    logic             result_valid;
    logic             result_stall = 1'b0;
    mqe_pkg::result_t result;

    mq_arithmetic_encoder dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // probability estimation tables of the mq coder
    logic [15:0] qe_tab [0:46] = '{
        16'h5601, 16'h3401, 16'h1801, 16'h0AC1, 16'h0521, 16'h0221, 16'h5601, 16'h5401,
        16'h4801, 16'h3801, 16'h3001, 16'h2401, 16'h1C01, 16'h1601, 16'h5601, 16'h5401,
        16'h5101, 16'h4801, 16'h3801, 16'h3401, 16'h3001, 16'h2801, 16'h2401, 16'h2201,
        16'h1C01, 16'h1801, 16'h1601, 16'h1401, 16'h1201, 16'h1101, 16'h0AC1, 16'h09C1,
        16'h08A1, 16'h0521, 16'h0441, 16'h02A1, 16'h0221, 16'h0141, 16'h0111, 16'h0085,
        16'h0049, 16'h0025, 16'h0015, 16'h0009, 16'h0005, 16'h0001, 16'h5601};
    logic [5:0] after_mps [0:46] = '{
        6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd38, 6'd7,  6'd8,  6'd9,  6'd10, 6'd11, 6'd12,
        6'd13, 6'd29, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24,
        6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33, 6'd34, 6'd35, 6'd36,
        6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd44, 6'd45, 6'd45, 6'd46};
    logic [5:0] after_lps [0:46] = '{
        6'd1,  6'd6,  6'd9,  6'd12, 6'd29, 6'd33, 6'd6,  6'd14, 6'd14, 6'd14, 6'd17, 6'd18,
        6'd20, 6'd21, 6'd14, 6'd14, 6'd15, 6'd16, 6'd17, 6'd18, 6'd19, 6'd19, 6'd20, 6'd21,
        6'd22, 6'd23, 6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd33,
        6'd34, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39, 6'd40, 6'd41, 6'd42, 6'd43, 6'd46};

    // coder state as the testbench tracks it
    logic [5:0]  cx_state [0:NCTX-1];
    logic        cx_mps   [0:NCTX-1];
    logic [15:0] a_reg;
    logic [27:0] c_reg;
    logic [3:0]  ct_reg;
    logic [7:0]  held_byte;
    logic        held_ok;

    mqe_pkg::result_t step_bytes[$];     // bytes caused by the word being worked out
    mqe_pkg::result_t code_bytes_due[$]; // bytes still to come from the block, oldest first
    row_t             plan[$];           // directed words

    int  bad_words     = 0;
    int  words_sent    = 0;
    int  cycles        = 0;
    int  pause_odds    = 4;
    bit  long_hold     = 1'b0;
    bit  calm          = 1'b0;
    mqe_pkg::result_t want;

    // ---------------------------------------------------------------- predictor

    task automatic put_byte(input logic [7:0] b);
        mqe_pkg::result_t r;
        begin
            r.out_byte = b;
            r.last     = 1'b0;
            // no word ever gives more than three bytes
            if (step_bytes.size() < 3)
                step_bytes.push_back(r);
        end
    endtask

    // move one byte out of C, with carry into the held byte and 0xff stuffing
    task automatic ship_byte();
        logic [7:0] b;
        logic       stuffed;
        begin
            b       = held_ok ? held_byte : 8'h00;
            stuffed = 1'b0;
            if (b == mqe_pkg::BYTE_FF)
                stuffed = 1'b1;
            else if (c_reg[27])
            begin
                // carry; with no byte held it is dropped
                b = b + 8'd1;
                if (held_ok)
                    held_byte = b;
                if (b == mqe_pkg::BYTE_FF)
                begin
                    c_reg   = c_reg & mqe_pkg::C_NO_MSB;
                    stuffed = 1'b1;
                end
            end
            if (held_ok)
                put_byte(held_byte);
            if (stuffed)
            begin
                held_byte = c_reg[27:20];
                c_reg     = c_reg & 28'h00FFFFF;
                ct_reg    = mqe_pkg::CT_STUFF;
            end
            else
            begin
                held_byte = c_reg[26:19];
                c_reg     = c_reg & 28'h007FFFF;
                ct_reg    = mqe_pkg::CT_PLAIN;
            end
            held_ok = 1'b1;
        end
    endtask

    task automatic renorm();
        begin
            do
            begin
                a_reg  = a_reg << 1;
                c_reg  = c_reg << 1;
                ct_reg = ct_reg - 4'd1;
                if (ct_reg == 4'd0)
                    ship_byte();
            end
            while (!a_reg[15] && a_reg != 16'h0000);
        end
    endtask

    task automatic code_decision(input int cx, input logic d);
        logic [5:0]  st;
        logic [15:0] qe;
        begin
            st = cx_state[cx];
            if (st > mqe_pkg::LAST_STATE)
                st = mqe_pkg::LAST_STATE;
            qe    = qe_tab[st];
            a_reg = a_reg - qe;
            if (cx_mps[cx] == d)
            begin
                if (!a_reg[15])
                begin
                    // conditional exchange on the mps path
                    if (a_reg < qe)
                        a_reg = qe;
                    else
                        c_reg = c_reg + 28'(qe);
                    cx_state[cx] = after_mps[st];
                    renorm();
                end
                else
                    c_reg = c_reg + 28'(qe);
            end
            else
            begin
                if (a_reg < qe)
                    c_reg = c_reg + 28'(qe);
                else
                    a_reg = qe;
                // the mps flips only on the switch states, never on the fixed last one
                if (qe == mqe_pkg::QE_SWITCH && st != mqe_pkg::LAST_STATE)
                    cx_mps[cx] = ~cx_mps[cx];
                cx_state[cx] = after_lps[st];
                renorm();
            end
        end
    endtask

    task automatic terminate_codeword();
        logic [28:0] span_end;
        begin
            // setbits: largest value inside the interval with low bits set
            span_end = 29'(a_reg) + 29'(c_reg);
            c_reg    = c_reg | mqe_pkg::C_LOW16;
            if ({1'b0, c_reg} >= span_end)
                c_reg = c_reg - mqe_pkg::C_HALF;
            c_reg = c_reg << ct_reg;
            ship_byte();
            c_reg = c_reg << ct_reg;
            ship_byte();
            // a trailing 0xff is left off the stream
            if (held_ok && held_byte != mqe_pkg::BYTE_FF)
                put_byte(held_byte);
            held_ok = 1'b0;
        end
    endtask

    task automatic open_codeword();
        begin
            a_reg     = mqe_pkg::A_INIT;
            c_reg     = '0;
            ct_reg    = mqe_pkg::CT_INIT;
            held_byte = 8'h00;
            held_ok   = 1'b0;
        end
    endtask

    task automatic coder_reset();
        begin
            for (int i = 0; i < NCTX; i++)
            begin
                cx_state[i] = (i == 0) ? mqe_pkg::LAST_STATE
                            : (i == 1) ? 6'd3 : (i == 2) ? 6'd4 : 6'd0;
                cx_mps[i]   = 1'b0;
            end
            open_codeword();
        end
    endtask

    // work out the code bytes one accepted command word causes
    task automatic encode_command(input mqe_pkg::item_t w);
        mqe_pkg::result_t r;
        begin
            step_bytes.delete();
            case (w.cmd)
                mqe_pkg::CMD_ENCODE:
                    if (int'(w.context_req) < NCTX)
                        code_decision(int'(w.context_req), w.decision);
                mqe_pkg::CMD_FLUSH:
                    terminate_codeword();
                mqe_pkg::CMD_LOAD:
                    if (int'(w.context_req) < NCTX)
                    begin
                        cx_state[w.context_req] = (w.init_state > mqe_pkg::LAST_STATE)
                                                  ? mqe_pkg::LAST_STATE : w.init_state;
                        cx_mps[w.context_req]   = w.init_mps;
                    end
                default:
                    open_codeword();
            endcase
            if (step_bytes.size() > 0)
            begin
                r      = step_bytes.pop_back();
                r.last = 1'b1;
                step_bytes.push_back(r);
            end
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    function automatic mqe_pkg::item_t make_word(input mqe_pkg::cmd_t c, input int cx,
                                                 input int d, input int st, input int m);
        mqe_pkg::item_t w;
        begin
            w.cmd         = c;
            w.context_req = cx[4:0];
            w.decision    = d[0];
            w.init_state  = st[5:0];
            w.init_mps    = m[0];
            return w;
        end
    endfunction

    task automatic add_row(input mqe_pkg::cmd_t c, input int cx, input int d, input int st,
                           input int m, input int typed, input int n,
                           input logic [7:0] b0, input logic [7:0] b1);
        row_t r;
        begin
            r.w     = make_word(c, cx, d, st, m);
            r.typed = (typed != 0);
            r.n     = n[1:0];
            r.b0    = b0;
            r.b1    = b1;
            plan.push_back(r);
        end
    endtask

    // hold the word on the channel until the block takes it
    task automatic offer(input mqe_pkg::item_t w);
        begin
            item       <= w;
            item_valid <= 1'b1;
            do
                @(posedge clk);
            while (item_stall);
        end
    endtask

    task automatic maybe_pause();
        begin
            if (!calm && !long_hold && pause_odds != 0 && $urandom_range(0, pause_odds - 1) == 0)
            begin
                item_valid <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end
    endtask

    task automatic send_row(input row_t r);
        mqe_pkg::result_t b;
        begin
            offer(r.w);
            encode_command(r.w);
            if (r.typed)
            begin
                // hand-written bytes stand in for the predicted ones
                for (int k = 0; k < int'(r.n); k++)
                begin
                    b.out_byte = (k == 0) ? r.b0 : r.b1;
                    b.last     = (k == int'(r.n) - 1);
                    code_bytes_due.push_back(b);
                end
            end
            else
            begin
                foreach (step_bytes[k])
                    code_bytes_due.push_back(step_bytes[k]);
            end
            words_sent++;
            maybe_pause();
        end
    endtask

    task automatic send_word(input mqe_pkg::item_t w);
        row_t r;
        begin
            r       = '0;
            r.w     = w;
            send_row(r);
        end
    endtask

    function automatic int pick_context();
        begin
            // mostly live contexts, now and then any label the field can hold
            if ($urandom_range(0, 11) == 0)
                return $urandom_range(0, 31);
            return $urandom_range(0, NCTX - 1);
        end
    endfunction

    initial
    begin : sender
        int  cx;
        int  n_enc;
        bit  drained;
        int  d;

        drained = 1'b0;
        coder_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        // flush straight out of reset: SETBITS gives 0x7fff, bytes ff then 7f
        add_row(mqe_pkg::CMD_FLUSH,  0,  0, 0,  0, 1, 2, 8'hFF, 8'h7F);
        // second flush with shift count 7: byte 07, then a trailing ff that is dropped
        add_row(mqe_pkg::CMD_FLUSH,  0,  0, 0,  0, 1, 1, 8'h07, 8'h00);
        add_row(mqe_pkg::CMD_START,  0,  0, 0,  0, 1, 0, 8'h00, 8'h00);
        // labels out of range are ignored
        add_row(mqe_pkg::CMD_ENCODE, 31, 1, 63, 1, 1, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_LOAD,   NCTX, 1, 63, 1, 1, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_LOAD,   31, 0, 0,  0, 1, 0, 8'h00, 8'h00);
        // state index above the table is clamped
        add_row(mqe_pkg::CMD_LOAD,   NCTX - 1, 0, 63, 1, 1, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_ENCODE, NCTX - 1, 1, 0,  0, 0, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_ENCODE, NCTX - 1, 0, 0,  0, 0, 0, 8'h00, 8'h00);
        // lps on state 0 flips the mps
        add_row(mqe_pkg::CMD_LOAD,   5,  0, 0,  0, 1, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_ENCODE, 5,  1, 0,  0, 0, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_ENCODE, 5,  1, 0,  0, 0, 0, 8'h00, 8'h00);
        // smallest qe: long mps runs, then an lps with a full renormalization
        add_row(mqe_pkg::CMD_LOAD,   6,  0, 45, 1, 1, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_ENCODE, 6,  1, 0,  0, 0, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_ENCODE, 6,  1, 0,  0, 0, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_ENCODE, 6,  1, 0,  0, 0, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_ENCODE, 6,  0, 0,  0, 0, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_ENCODE, 1,  0, 0,  0, 0, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_ENCODE, 2,  1, 0,  0, 0, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_ENCODE, 0,  0, 0,  0, 0, 0, 8'h00, 8'h00);
        // start drops whatever byte is held
        add_row(mqe_pkg::CMD_START,  0,  0, 0,  0, 1, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_ENCODE, 0,  1, 0,  0, 0, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_FLUSH,  0,  0, 0,  0, 0, 0, 8'h00, 8'h00);
        // coding on after a flush, no start in between
        add_row(mqe_pkg::CMD_ENCODE, 7,  1, 0,  0, 0, 0, 8'h00, 8'h00);
        add_row(mqe_pkg::CMD_FLUSH,  0,  0, 0,  0, 0, 0, 8'h00, 8'h00);
        foreach (plan[i])
            send_row(plan[i]);

        // random part: codewords with random content, some noise and broken ones;
        // the output side starts with a long hold so the block backs up
        long_hold = 1'b1;
        while (words_sent < ITEMS)
        begin
            case ($urandom_range(0, 2))
                0: pause_odds = 0;
                1: pause_odds = 8;
                default: pause_odds = 2;
            endcase
            if ($urandom_range(0, 9) != 0)
                send_word(make_word(mqe_pkg::CMD_START, $urandom_range(0, 31),
                                    $urandom_range(0, 1), $urandom_range(0, 63),
                                    $urandom_range(0, 1)));
            repeat ($urandom_range(0, 3))
                send_word(make_word(mqe_pkg::CMD_LOAD, pick_context(), $urandom_range(0, 1),
                                    $urandom_range(0, 63), $urandom_range(0, 1)));
            n_enc = $urandom_range(4, 40);
            repeat (n_enc)
            begin
                if ($urandom_range(0, 19) == 0)
                    send_word(make_word(mqe_pkg::cmd_t'($urandom_range(0, 3)),
                                        $urandom_range(0, 31), $urandom_range(0, 1),
                                        $urandom_range(0, 63), $urandom_range(0, 1)));
                else
                begin
                    cx = pick_context();
                    // lean toward the mps so runs build up
                    if (cx < NCTX && $urandom_range(0, 3) != 0)
                        d = int'(cx_mps[cx]);
                    else
                        d = $urandom_range(0, 1);
                    send_word(make_word(mqe_pkg::CMD_ENCODE, cx, d, $urandom_range(0, 63),
                                        $urandom_range(0, 1)));
                end
            end
            if ($urandom_range(0, 6) != 0)
                send_word(make_word(mqe_pkg::CMD_FLUSH, $urandom_range(0, 31),
                                    $urandom_range(0, 1), $urandom_range(0, 63),
                                    $urandom_range(0, 1)));
            // once, let the block run dry before going on
            if (!drained && words_sent > ITEMS / 2)
            begin
                drained = 1'b1;
                item_valid <= 1'b0;
                while (code_bytes_due.size() != 0)
                    @(posedge clk);
            end
            if (words_sent > ITEMS * 85 / 100)
                calm = 1'b1;
        end
        item_valid <= 1'b0;

        // drain, then give the block time to show any stray word
        while (code_bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        @(negedge clk);
        if (bad_words == 0 && code_bytes_due.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // output side: random stall bursts, one long hold, none near the end
    initial
    begin : receiver
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else if (calm)
            begin
                result_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                result_stall <= ($urandom_range(0, 2) == 0);
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
        end
    end

    // compare every accepted code byte with the oldest one due
    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            if (code_bytes_due.size() == 0)
            begin
                if (bad_words < 10)
                    $display("unexpected word: out_byte %h last %b", result.out_byte,
                             result.last);
                bad_words++;
            end
            else
            begin
                want = code_bytes_due.pop_front();
                if (result.out_byte !== want.out_byte || result.last !== want.last)
                begin
                    if (bad_words < 10)
                        $display("mismatch: out_byte exp %h got %h, last exp %b got %b",
                                 want.out_byte, result.out_byte, want.last, result.last);
                    bad_words++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

endmodule
